[rtl/core/ssfuv_pkg.sv]
// shared widths, register codes and the long-division step for the sprite frame uv core
`default_nettype none

package ssfuv_pkg;

  localparam int FRAME_W    = 16;
  localparam int CELL_W     = 16;
  localparam int LAST_W     = 2 * CELL_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // lanes of the corner and inset dividers
  localparam int LN_U0  = 0;
  localparam int LN_U1  = 1;
  localparam int LN_V0  = 2;
  localparam int LN_V1  = 3;
  localparam int LN_IU  = 4;
  localparam int LN_IV  = 5;
  localparam int NLANE  = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLUMNS   = 3'd0,
    CFG_GRID_ROWS      = 3'd1,
    CFG_FLIP_ROW_ORDER = 3'd2,
    CFG_IMAGE_PRESENT  = 3'd3,
    CFG_IMAGE_WIDTH    = 3'd4,
    CFG_IMAGE_HEIGHT   = 3'd5
  } cfg_reg_t;

  typedef logic [CELL_W-1:0] cell_t;

  typedef struct packed {
    cell_t rem;
    logic  qbit;
  } div_step_t;

  // one restoring division step: shift in a dividend bit, subtract if it fits
  function automatic div_step_t div_step(input cell_t rem, input logic bin,
                                         input cell_t divisor);
    logic [CELL_W:0] trial;
    div_step_t       res;
    trial = {rem, bin};
    if (trial >= {1'b0, divisor}) begin
      res.rem  = CELL_W'(trial - {1'b0, divisor});
      res.qbit = 1'b1;
    end else begin
      res.rem  = trial[CELL_W-1:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/sprite_sheet_frame_uv_core.sv]
// texture rectangle of one frame in a grid sprite sheet, fully pipelined
`default_nettype none

// Takes one frame number per clock and returns its uv rectangle and grid cell,
// one word per clock while the output is not stalled, in order. 16
// restoring-division stages split the clamped frame into row and column, then
// UV_FRAC_BITS stages of six parallel division lanes give the four corners and
// the two half-texel insets, plus input, setup, inset decision and output stages.
// A stall on the output holds every stage; the input stage still takes one more
// word while the pipeline waits. Configuration writes are taken at any time
// (cfg_ready is always high) but must only be made while no word is in flight.
module sprite_sheet_frame_uv_core
  import ssfuv_pkg::*;
#(
  parameter int UV_FRAC_BITS = 16,
  localparam int UV_W     = UV_FRAC_BITS + 1,
  localparam int OUT_BITS = 4 * UV_W + 2 * CELL_W,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [FRAME_W-1:0]    s_tdata,   // frame_number
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // u_start, v_start, u_end, v_end, cell_column, cell_row, zero pad
  output logic [OUT_W-1:0]           m_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int F = UV_FRAC_BITS;
  localparam logic [F-1:0] HALF_DQ = F'(1) << (F - 1);

  // configuration registers
  cell_t grid_columns;
  cell_t grid_rows;
  logic  flip_row_order;
  logic  image_present;
  cell_t image_width_px;
  cell_t image_height_px;

  cell_t             cols_eff;
  cell_t             rows_eff;
  logic [LAST_W-1:0] last_cell;
  logic              inset_en;

  logic adv;

  // input stage
  logic               in_vld;
  logic [FRAME_W-1:0] in_frame;
  logic [FRAME_W-1:0] frame_clamped;

  // frame / columns
  logic               dv_vld  [FRAME_W+1];
  cell_t              dv_rem  [FRAME_W+1];
  logic [FRAME_W-1:0] dv_dq   [FRAME_W+1];
  div_step_t          dv_step [FRAME_W];

  // column and flipped row
  logic  pp_vld;
  cell_t pp_col;
  cell_t pp_row;
  cell_t row_q;

  // corner and inset lanes
  cell_t     lane_div [NLANE];
  logic      ln_vld   [F+1];
  cell_t     ln_rem   [F+1][NLANE];
  logic [F-1:0] ln_q  [F+1][NLANE];
  logic      ln_uint  [F+1];
  logic      ln_vint  [F+1];
  cell_t     ln_col   [F+1];
  cell_t     ln_row   [F+1];
  div_step_t ln_step  [F][NLANE];

  logic [UV_W-1:0] fin_u0, fin_u1, fin_v0, fin_v1;

  // inset decision
  logic            ck_vld;
  logic [UV_W-1:0] ck_u0, ck_u1, ck_v0, ck_v1;
  logic [F-1:0]    ck_iu, ck_iv;
  cell_t           ck_col, ck_row;
  logic            ck_flag;

  // output register
  logic            out_vld;
  logic [UV_W-1:0] out_u0, out_u1, out_v0, out_v1;
  cell_t           out_col, out_row;
  logic [OUT_BITS-1:0] out_packed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns    <= CELL_W'(1);
      grid_rows       <= CELL_W'(1);
      flip_row_order  <= 1'b0;
      image_present   <= 1'b0;
      image_width_px  <= '0;
      image_height_px <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GRID_COLUMNS:   grid_columns    <= cfg_data;
        CFG_GRID_ROWS:      grid_rows       <= cfg_data;
        CFG_FLIP_ROW_ORDER: flip_row_order  <= cfg_data[0];
        CFG_IMAGE_PRESENT:  image_present   <= cfg_data[0];
        CFG_IMAGE_WIDTH:    image_width_px  <= cfg_data;
        CFG_IMAGE_HEIGHT:   image_height_px <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cols_eff = (grid_columns == '0) ? CELL_W'(1) : grid_columns;
  assign rows_eff = (grid_rows == '0) ? CELL_W'(1) : grid_rows;
  assign inset_en = image_present && (image_width_px > CELL_W'(1))
                    && (image_height_px > CELL_W'(1))
                    && ((cols_eff > CELL_W'(1)) || (rows_eff > CELL_W'(1)));

  // last cell index, registered off the multiplier
  always_ff @(posedge clk) begin
    last_cell <= LAST_W'(cols_eff) * LAST_W'(rows_eff) - LAST_W'(1);
  end

  // whole pipeline moves together; the input stage also fills when empty
  assign adv      = !out_vld || m_tready;
  assign s_tready = adv || !in_vld;

  assign frame_clamped = (LAST_W'(in_frame) > last_cell) ? last_cell[FRAME_W-1:0]
                                                        : in_frame;

  always_comb begin
    for (int k = 0; k < FRAME_W; k++) begin
      dv_step[k] = div_step(dv_rem[k], dv_dq[k][FRAME_W-1], cols_eff);
    end
  end

  assign row_q = dv_dq[FRAME_W][CELL_W-1:0];

  always_comb begin
    lane_div[LN_U0] = cols_eff;
    lane_div[LN_U1] = cols_eff;
    lane_div[LN_V0] = rows_eff;
    lane_div[LN_V1] = rows_eff;
    lane_div[LN_IU] = image_width_px;
    lane_div[LN_IV] = image_height_px;
  end

  always_comb begin
    for (int k = 0; k < F; k++) begin
      for (int l = 0; l < NLANE; l++) begin
        ln_step[k][l] = div_step(ln_rem[k][l], ln_q[k][l][F-1], lane_div[l]);
      end
    end
  end

  assign fin_u0 = {1'b0, ln_q[F][LN_U0]};
  assign fin_u1 = {ln_uint[F], ln_q[F][LN_U1]};
  assign fin_v0 = {1'b0, ln_q[F][LN_V0]};
  assign fin_v1 = {ln_vint[F], ln_q[F][LN_V1]};

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      pp_vld  <= 1'b0;
      ck_vld  <= 1'b0;
      out_vld <= 1'b0;
      for (int k = 0; k <= FRAME_W; k++) dv_vld[k] <= 1'b0;
      for (int k = 0; k <= F; k++) ln_vld[k] <= 1'b0;
    end else begin
      if (s_tready) in_vld <= s_tvalid;
      if (adv) begin
        dv_vld[0] <= in_vld;
        for (int k = 0; k < FRAME_W; k++) dv_vld[k+1] <= dv_vld[k];
        pp_vld    <= dv_vld[FRAME_W];
        ln_vld[0] <= pp_vld;
        for (int k = 0; k < F; k++) ln_vld[k+1] <= ln_vld[k];
        ck_vld  <= ln_vld[F];
        out_vld <= ck_vld;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tready) in_frame <= s_tdata;
    if (adv) begin
      dv_rem[0] <= '0;
      dv_dq[0]  <= frame_clamped;
      for (int k = 0; k < FRAME_W; k++) begin
        dv_rem[k+1] <= dv_step[k].rem;
        dv_dq[k+1]  <= {dv_dq[k][FRAME_W-2:0], dv_step[k].qbit};
      end

      pp_col <= dv_rem[FRAME_W];
      pp_row <= flip_row_order ? (rows_eff - CELL_W'(1) - row_q) : row_q;

      // corner lanes start from the remainder k; k equal to the count is exactly one
      ln_uint[0]       <= (pp_col == cols_eff - CELL_W'(1));
      ln_vint[0]       <= (pp_row == rows_eff - CELL_W'(1));
      ln_col[0]        <= pp_col;
      ln_row[0]        <= pp_row;
      ln_rem[0][LN_U0] <= pp_col;
      ln_rem[0][LN_U1] <= (pp_col == cols_eff - CELL_W'(1)) ? '0 : pp_col + CELL_W'(1);
      ln_rem[0][LN_V0] <= pp_row;
      ln_rem[0][LN_V1] <= (pp_row == rows_eff - CELL_W'(1)) ? '0 : pp_row + CELL_W'(1);
      ln_rem[0][LN_IU] <= '0;
      ln_rem[0][LN_IV] <= '0;
      ln_q[0][LN_U0]   <= '0;
      ln_q[0][LN_U1]   <= '0;
      ln_q[0][LN_V0]   <= '0;
      ln_q[0][LN_V1]   <= '0;
      ln_q[0][LN_IU]   <= HALF_DQ;
      ln_q[0][LN_IV]   <= HALF_DQ;
      for (int k = 0; k < F; k++) begin
        ln_uint[k+1] <= ln_uint[k];
        ln_vint[k+1] <= ln_vint[k];
        ln_col[k+1]  <= ln_col[k];
        ln_row[k+1]  <= ln_row[k];
        for (int l = 0; l < NLANE; l++) begin
          ln_rem[k+1][l] <= ln_step[k][l].rem;
          ln_q[k+1][l]   <= {ln_q[k][l][F-2:0], ln_step[k][l].qbit};
        end
      end

      ck_u0   <= fin_u0;
      ck_u1   <= fin_u1;
      ck_v0   <= fin_v0;
      ck_v1   <= fin_v1;
      ck_iu   <= ln_q[F][LN_IU];
      ck_iv   <= ln_q[F][LN_IV];
      ck_col  <= ln_col[F];
      ck_row  <= ln_row[F];
      ck_flag <= inset_en
                 && ((fin_u1 - fin_u0) > {ln_q[F][LN_IU], 1'b0})
                 && ((fin_v1 - fin_v0) > {ln_q[F][LN_IV], 1'b0});

      out_col <= ck_col;
      out_row <= ck_row;
      if (ck_flag) begin
        out_u0 <= ck_u0 + UV_W'(ck_iu);
        out_u1 <= ck_u1 - UV_W'(ck_iu);
        out_v0 <= ck_v0 + UV_W'(ck_iv);
        out_v1 <= ck_v1 - UV_W'(ck_iv);
      end else begin
        out_u0 <= ck_u0;
        out_u1 <= ck_u1;
        out_v0 <= ck_v0;
        out_v1 <= ck_v1;
      end
    end
  end

  assign out_packed = {out_row, out_col, out_v1, out_u1, out_v0, out_u0};
  assign m_tdata    = OUT_W'(out_packed);
  assign m_tvalid   = out_vld;

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

  // a word only shows up on the output out of the inset stage
  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(ck_vld))
    else $error("output word without a word in the inset stage");

  // a corner of exactly one leaves no fraction bits
  a_u_end_one: assert property (@(posedge clk) disable iff (rst)
    (ln_vld[F] && ln_uint[F]) |-> (ln_q[F][LN_U1] == '0))
    else $error("u end above one");

  a_v_end_one: assert property (@(posedge clk) disable iff (rst)
    (ln_vld[F] && ln_vint[F]) |-> (ln_q[F][LN_V1] == '0))
    else $error("v end above one");

endmodule

`default_nettype wire
